/* rtl/keyword_token_classifier_core_assert.svh */
// Assertion macros used by the checker file of the keyword classifier.
`ifndef KEYWORD_TOKEN_CLASSIFIER_CORE_ASSERT_SVH
`define KEYWORD_TOKEN_CLASSIFIER_CORE_ASSERT_SVH

// Concurrent assertion sampled on the rising clock edge, off while in reset.
`define KTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent, built on the macro above.
`define KTC_ASSERT_NEXT(lbl, pre, post, msg) \
  `KTC_ASSERT(lbl, (pre) |=> (post), msg)

`endif

/* rtl/kwtc_pkg.sv */
// Types, keyword table and constants of the keyword token classifier.
`default_nettype none

package kwtc_pkg;

  // Fixed widths of the word fields.
  localparam int unsigned CharW   = 8;
  localparam int unsigned ClassW  = 5;
  localparam int unsigned PosW    = 4;
  localparam int unsigned KwCount = 23;
  // Keyword text is stored in a slot wide enough for any position value.
  localparam int unsigned KwSlotBytes = 2 ** PosW;

  typedef logic [CharW-1:0]   char_t;
  typedef logic [ClassW-1:0]  class_t;
  typedef logic [PosW-1:0]    pos_t;
  typedef logic [KwCount-1:0] kw_mask_t;
  typedef logic [KwSlotBytes*CharW-1:0] kw_text_t;

  localparam pos_t     PosMax   = '1;
  localparam kw_mask_t AllAlive = '1;
  localparam class_t   ClassIdent = '0;

  // Keywords in class order; the last character sits in the lowest byte.
  localparam kw_text_t KwText [KwCount] = '{
    kw_text_t'("on"),        kw_text_t'("null"),       kw_text_t'("true"),
    kw_text_t'("type"),      kw_text_t'("enum"),       kw_text_t'("false"),
    kw_text_t'("query"),     kw_text_t'("__get"),      kw_text_t'("union"),
    kw_text_t'("input"),     kw_text_t'("scalar"),     kw_text_t'("extends"),
    kw_text_t'("__delete"),  kw_text_t'("__schema"),   kw_text_t'("__update"),
    kw_text_t'("__create"),  kw_text_t'("mutation"),   kw_text_t'("fragment"),
    kw_text_t'("interface"), kw_text_t'("directive"),  kw_text_t'("implements"),
    kw_text_t'("__typename"), kw_text_t'("subscription")
  };

  localparam pos_t KwLen [KwCount] = '{
    4'd2, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10, 4'd12
  };

  // Outcome of matching one character against all keywords.
  typedef struct packed {
    kw_mask_t next_alive;
    pos_t     next_pos;
    class_t   token_class;
  } match_t;

endpackage

`default_nettype wire

/* rtl/kwtc_matcher.sv */
// Parallel compare of one character against every live keyword.
`default_nettype none

module kwtc_matcher #(
  parameter int unsigned MAX_WORD_LEN = 12
) (
  input  kwtc_pkg::char_t    char_i,
  input  kwtc_pkg::pos_t     pos_i,
  input  kwtc_pkg::kw_mask_t alive_i,
  output kwtc_pkg::match_t   match_o
);

  kwtc_pkg::kw_mask_t next_alive;
  kwtc_pkg::pos_t     word_len;
  kwtc_pkg::class_t   token_class;

  // Each keyword keeps living only if its character at this position matches.
  always_comb begin
    for (int k = 0; k < kwtc_pkg::KwCount; k++) begin
      kwtc_pkg::pos_t  byte_idx;
      kwtc_pkg::char_t kw_byte;
      byte_idx = kwtc_pkg::KwLen[k] - pos_i - kwtc_pkg::pos_t'(1);
      kw_byte  = kwtc_pkg::KwText[k][{byte_idx, 3'b000} +: kwtc_pkg::CharW];
      next_alive[k] = alive_i[k] && (pos_i < kwtc_pkg::KwLen[k]) && (kw_byte == char_i);
    end
  end

  // The position counter saturates at its top value.
  assign word_len = (pos_i < kwtc_pkg::PosMax) ? pos_i + kwtc_pkg::pos_t'(1)
                                              : kwtc_pkg::PosMax;

  // Keywords are distinct, so at most one survives with the exact length.
  always_comb begin
    token_class = kwtc_pkg::ClassIdent;
    if (word_len <= kwtc_pkg::pos_t'(MAX_WORD_LEN)) begin
      for (int k = 0; k < kwtc_pkg::KwCount; k++) begin
        if (next_alive[k] && (word_len == kwtc_pkg::KwLen[k])) begin
          token_class = token_class | kwtc_pkg::class_t'(k + 1);
        end
      end
    end
  end

  assign match_o.next_alive  = next_alive;
  assign match_o.next_pos    = word_len;
  assign match_o.token_class = token_class;

endmodule

`default_nettype wire

/* rtl/keyword_token_classifier_core.sv */
// Top level of the keyword token classifier.
// The class word is registered and valid in the cycle after the last character is accepted.
// Throughput: one character per cycle while the output is not stalled; back-to-back words are taken without gaps.
// The single output register decouples the sides; input stalls only when it is full
// and not being taken. Reset clears the position, the live-keyword mask and the
// output valid; no clearing pass is needed.
`default_nettype none

module keyword_token_classifier_core #(
  parameter int unsigned MAX_WORD_LEN = 12
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // [7:0] char_code
  input  wire        s_axis_tlast,   // is_last
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata    // [4:0] token_class, [7:5] zero
);

  kwtc_pkg::pos_t     pos_q, pos_d;
  kwtc_pkg::kw_mask_t alive_q, alive_d;
  logic               out_valid_q, out_valid_d;
  kwtc_pkg::class_t   class_q, class_d;
  kwtc_pkg::match_t   match;
  logic               in_word;

  kwtc_matcher #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_matcher (
    .char_i (s_axis_tdata),
    .pos_i  (pos_q),
    .alive_i(alive_q),
    .match_o(match)
  );

  // Input is taken whenever the output register is empty or being drained.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_word       = s_axis_tvalid && s_axis_tready;

  // Next state of the word tracker and the output register.
  always_comb begin
    pos_d       = pos_q;
    alive_d     = alive_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    class_d     = class_q;
    if (in_word) begin
      if (s_axis_tlast) begin
        pos_d       = '0;
        alive_d     = kwtc_pkg::AllAlive;
        out_valid_d = 1'b1;
        class_d     = match.token_class;
      end else begin
        pos_d   = match.next_pos;
        alive_d = match.next_alive;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      alive_q     <= kwtc_pkg::AllAlive;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      alive_q     <= alive_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    class_q <= class_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8 - kwtc_pkg::ClassW){1'b0}}, class_q};

endmodule

`default_nettype wire

/* rtl/kwtc_checker.sv */
// Port-level checker of the keyword token classifier and its bind.
`default_nettype none

`include "keyword_token_classifier_core_assert.svh"

module kwtc_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       s_axis_tvalid,
  input wire       s_axis_tready,
  input wire [7:0] s_axis_tdata,
  input wire       s_axis_tlast,
  input wire       m_axis_tvalid,
  input wire       m_axis_tready,
  input wire [7:0] m_axis_tdata
);

  logic in_word;
  logic unused_data;

  assign in_word     = s_axis_tvalid && s_axis_tready;
  assign unused_data = ^s_axis_tdata;

  // A stalled result word stays offered.
  `KTC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result word dropped while stalled")
  // Only identifier or one of the 23 keyword codes ever leaves the block.
  `KTC_ASSERT(a_class_range, m_axis_tvalid |-> (m_axis_tdata <= 8'd23 && unused_data == unused_data), "class code out of range")
  // An empty output register never blocks the input.
  `KTC_ASSERT(a_ready_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
  // The last character of a word yields a result word in the next cycle.
  `KTC_ASSERT_NEXT(a_last_result, in_word && s_axis_tlast, m_axis_tvalid, "no result after last character")
  // Characters inside a word produce no result of their own.
  `KTC_ASSERT_NEXT(a_no_spurious, in_word && !s_axis_tlast && !m_axis_tvalid, !m_axis_tvalid, "result word without last character")

endmodule

bind keyword_token_classifier_core kwtc_checker u_kwtc_checker (.*);

`default_nettype wire

/* tb/sv/keyword_token_classifier_core_tb.sv */
// Self-checking testbench of the keyword token classifier with its own class predictor.
module keyword_token_classifier_core_tb;

  localparam int unsigned WordLenCap = 12;
  localparam int unsigned NumDirected = 24;
  localparam int unsigned RandomItems = 650;
  localparam int unsigned NumPhases = 4;
  localparam int unsigned TailCycles = 8;

  // One directed row: a character, its last mark, and an optional fixed class.
  typedef struct packed {
    kwtc_pkg::char_t  code;
    logic             last;
    logic             fixed;
    kwtc_pkg::class_t want;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] char_code
  logic       s_axis_tlast;   // is_last
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [4:0] token_class, [7:5] zero

  // Keywords in class order, class 1 first.
  string kw_words [kwtc_pkg::KwCount] = '{
    "on", "null", "true", "type", "enum", "false", "query", "__get",
    "union", "input", "scalar", "extends", "__delete", "__schema",
    "__update", "__create", "mutation", "fragment", "interface",
    "directive", "implements", "__typename", "subscription"
  };

  // Directed words: a keyword, extreme bytes, the longest keyword, short words.
  stim_row_t dir_rows [NumDirected] = '{
    '{"o", 1'b0, 1'b0, kwtc_pkg::ClassIdent}, '{"n", 1'b1, 1'b1, 5'd1},
    '{8'hff, 1'b1, 1'b1, kwtc_pkg::ClassIdent},
    '{8'h00, 1'b1, 1'b1, kwtc_pkg::ClassIdent},
    '{"s", 1'b0, 1'b0, kwtc_pkg::ClassIdent}, '{"u", 1'b0, 1'b0, kwtc_pkg::ClassIdent},
    '{"b", 1'b0, 1'b0, kwtc_pkg::ClassIdent}, '{"s", 1'b0, 1'b0, kwtc_pkg::ClassIdent},
    '{"c", 1'b0, 1'b0, kwtc_pkg::ClassIdent}, '{"r", 1'b0, 1'b0, kwtc_pkg::ClassIdent},
    '{"i", 1'b0, 1'b0, kwtc_pkg::ClassIdent}, '{"p", 1'b0, 1'b0, kwtc_pkg::ClassIdent},
    '{"t", 1'b0, 1'b0, kwtc_pkg::ClassIdent}, '{"i", 1'b0, 1'b0, kwtc_pkg::ClassIdent},
    '{"o", 1'b0, 1'b0, kwtc_pkg::ClassIdent}, '{"n", 1'b1, 1'b1, 5'd23},
    '{"o", 1'b1, 1'b1, kwtc_pkg::ClassIdent},
    '{"o", 1'b0, 1'b0, kwtc_pkg::ClassIdent}, '{"f", 1'b1, 1'b0, kwtc_pkg::ClassIdent},
    '{"_", 1'b0, 1'b0, kwtc_pkg::ClassIdent}, '{"_", 1'b0, 1'b0, kwtc_pkg::ClassIdent},
    '{"g", 1'b0, 1'b0, kwtc_pkg::ClassIdent}, '{"e", 1'b0, 1'b0, kwtc_pkg::ClassIdent},
    '{"t", 1'b1, 1'b0, kwtc_pkg::ClassIdent}
  };

  // Predictor state: characters seen in the current word and keywords still matching.
  kwtc_pkg::pos_t     word_pos;
  kwtc_pkg::kw_mask_t live_mask;

  kwtc_pkg::class_t pending_classes [$];
  kwtc_pkg::char_t  word_buf [$];
  kwtc_pkg::class_t exp_class;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned char_count;
  int unsigned word_count;
  int unsigned class_count;
  logic [31:0] class_seen;

  keyword_token_classifier_core #(
    .MAX_WORD_LEN(WordLenCap)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with a period of 10.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Advance the predictor by one character; returns 1 when a class word is due.
  function automatic bit classify_char(input kwtc_pkg::char_t code, input bit last,
                                       output kwtc_pkg::class_t cls);
    kwtc_pkg::kw_mask_t next_live;
    kwtc_pkg::pos_t     len;
    bit                 found;
    next_live = '0;
    cls = kwtc_pkg::ClassIdent;
    found = 1'b0;
    for (int k = 0; k < kwtc_pkg::KwCount; k++) begin
      if (live_mask[k] && word_pos < kw_words[k].len() && kw_words[k][word_pos] == code) begin
        next_live[k] = 1'b1;
      end
    end
    len = (word_pos < kwtc_pkg::PosMax) ? word_pos + 4'd1 : kwtc_pkg::PosMax;
    if (!last) begin
      word_pos = len;
      live_mask = next_live;
      return 1'b0;
    end
    // Only a word within the length cap can be a keyword; the first full match wins.
    if (len <= WordLenCap) begin
      for (int k = 0; k < kwtc_pkg::KwCount; k++) begin
        if (!found && next_live[k] && kw_words[k].len() == len) begin
          cls = kwtc_pkg::class_t'(k + 1);
          found = 1'b1;
        end
      end
    end
    word_pos = '0;
    live_mask = kwtc_pkg::AllAlive;
    return 1'b1;
  endfunction

  // Offer one character, entered and left at a falling edge.
  task automatic send_char(input kwtc_pkg::char_t code, input bit last, input bit fixed,
                           input kwtc_pkg::class_t want);
    kwtc_pkg::class_t cls;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= code;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    char_count++;
    if (classify_char(code, last, cls)) begin
      pending_classes.push_back(fixed ? want : cls);
      word_count++;
    end
    @(negedge clk_i);
  endtask

  // Send the word held in the buffer, marking its final character.
  task automatic send_word_buf();
    for (int i = 0; i < word_buf.size(); i++) begin
      send_char(word_buf[i], i == word_buf.size() - 1, 1'b0, kwtc_pkg::ClassIdent);
    end
  endtask

  // Build a random word: mostly keywords and near misses, the rest noise.
  task automatic build_random_word();
    int unsigned kind;
    int unsigned k;
    int unsigned len;
    int unsigned pick;
    kind = $urandom_range(99);
    k = $urandom_range(kwtc_pkg::KwCount - 1);
    word_buf.delete();
    if (kind < 75) begin
      for (int i = 0; i < kw_words[k].len(); i++) word_buf.push_back(kw_words[k][i]);
    end
    if (kind >= 40 && kind < 55) begin
      // Keyword with one character replaced.
      word_buf[$urandom_range(word_buf.size() - 1)] = kwtc_pkg::char_t'($urandom_range(255));
    end else if (kind >= 55 && kind < 65) begin
      // Keyword prefix, cut by at least one character.
      len = $urandom_range(word_buf.size() - 1, 1);
      while (word_buf.size() > len) void'(word_buf.pop_back());
    end else if (kind >= 65 && kind < 75) begin
      // Keyword followed by extra letters.
      len = $urandom_range(5, 1);
      for (int i = 0; i < len; i++) begin
        word_buf.push_back("a" + kwtc_pkg::char_t'($urandom_range(25)));
      end
    end else if (kind >= 75 && kind < 85) begin
      // Short word from the keyword alphabet.
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(26);
        word_buf.push_back(pick == 26 ? "_" : "a" + kwtc_pkg::char_t'(pick));
      end
    end else if (kind >= 85 && kind < 95) begin
      // Arbitrary bytes, sometimes past the saturation point.
      len = $urandom_range(20, 1);
      for (int i = 0; i < len; i++) word_buf.push_back(kwtc_pkg::char_t'($urandom_range(255)));
    end else if (kind >= 95) begin
      // Longest keyword run on past the cap.
      for (int i = 0; i < kw_words[kwtc_pkg::KwCount-1].len(); i++) begin
        word_buf.push_back(kw_words[kwtc_pkg::KwCount-1][i]);
      end
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        word_buf.push_back("a" + kwtc_pkg::char_t'($urandom_range(25)));
      end
    end
  endtask

  // Receiver ready, redrawn at each falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted class word with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_classes.size() == 0) begin
        $display("%0t: class word %h with nothing expected", $time, m_axis_tdata);
        error_count++;
      end else begin
        exp_class = pending_classes.pop_front();
        if (m_axis_tdata !== {3'b000, exp_class}) begin
          $display("%0t: class word mismatch, expected %h, actual %h",
                   $time, {3'b000, exp_class}, m_axis_tdata);
          error_count++;
        end
        class_seen[m_axis_tdata[4:0]] = 1'b1;
      end
    end
  end

  // Stimulus: reset, directed rows, then random words under four idling phases.
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    char_count = 0;
    word_count = 0;
    class_seen = '0;
    word_pos = '0;
    live_mask = kwtc_pkg::AllAlive;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    for (int r = 0; r < NumDirected; r++) begin
      send_char(dir_rows[r].code, dir_rows[r].last, dir_rows[r].fixed, dir_rows[r].want);
    end
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 55; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 55; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      while (char_count < NumDirected + (ph + 1) * RandomItems / NumPhases) begin
        build_random_word();
        send_word_buf();
      end
      // Hold the sender until every class word of this phase has come back.
      s_axis_tvalid <= 1'b0;
      while (pending_classes.size() != 0) @(posedge clk_i);
      @(negedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    class_count = $countones(class_seen);
    $display("Sent %0d characters in %0d words over four idling phases.",
             char_count, word_count);
    $display("%0d of 24 token classes came back.", class_count);
    if (error_count == 0) begin
      $display("keyword_token_classifier_core regression: pass");
    end else begin
      $display("keyword_token_classifier_core regression: fail");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Timeout with %0d class words outstanding.", pending_classes.size());
    $display("keyword_token_classifier_core regression: fail");
    $finish;
  end

endmodule
